FILE: design/lphm_pkg.sv
// Shared types and codes for the largest-pair heap matcher.
package lphm_pkg;

   localparam int ID_BITS = 11;
   localparam logic [ID_BITS-1:0] ID_MAX = 11'd2047;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_PAIR  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FEW  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [17:0] count_value;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] first_id;
      logic [ID_BITS-1:0] second_id;
      logic [1:0]         status;
   } rsp_type;

endpackage

FILE: design/lphm_heap_ram.sv
// Heap entry memory: one write port, one read port, registered read data.
module lphm_heap_ram #(
   parameter int WIDTH = 29,
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/largest_pair_heap_matcher.sv
// Top level of the largest-pair heap matcher.
//
// Requests enter on req_valid/req_stall with req_data (action, count_value);
// one response per request leaves on rsp_valid/rsp_stall with rsp_data.
// A load assigns the next id and inserts a nonzero count into a max-heap
// held in a single-port-read memory; a pair pops the two largest entries,
// reports their ids and reinserts each one whose count is above one with
// that count lowered by one; a clear empties the heap and restarts ids at one.
// One request is in work at a time. Every heap step is one memory read
// plus a compare. A load sifts its new entry up; a pair runs two pops
// (root and last entry read, then a sift down) and up to two pushes that
// sift up. Clears, zero or dropped loads and short pairs go straight to
// the done state. The next request is taken the cycle after the response
// is registered.
// A finished response sits in an output register; the next request is taken
// while it waits, but its own response holds until rsp_stall drops.
// Synchronous reset empties the heap, sets the next id to one and drops
// any pending response. Memory contents are not cleared: only entries
// below the heap size are ever read.
module largest_pair_heap_matcher
   import lphm_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int COUNT_BITS = 18
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int EW = COUNT_BITS + ID_BITS;
   localparam logic [AW:0] CAP = (AW+1)'(CAPACITY);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_POP_ROOT = 4'd1;
   localparam logic [3:0] S_POP_LAST = 4'd2;
   localparam logic [3:0] S_DN_CHK   = 4'd3;
   localparam logic [3:0] S_DN_L     = 4'd4;
   localparam logic [3:0] S_DN_R     = 4'd5;
   localparam logic [3:0] S_UP_CHK   = 4'd6;
   localparam logic [3:0] S_UP_P     = 4'd7;
   localparam logic [3:0] S_NEXT     = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   localparam logic [EW-1:0] ONE_CNT = {COUNT_BITS'(1), ID_BITS'(0)};

   logic [3:0]         state_ff, state_in;
   logic [AW:0]        size_ff, size_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [EW-1:0]      cur_ff, cur_in;
   logic [EW-1:0]      lch_ff, lch_in;
   logic               lbet_ff, lbet_in;
   logic [EW-1:0]      ent_a_ff, ent_a_in;
   logic [EW-1:0]      ent_b_ff, ent_b_in;
   logic [1:0]         ph_ff, ph_in;
   logic               is_load_ff, is_load_in;
   rsp_type            pend_ff, pend_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;
   logic [AW-1:0]      rd_addr;
   logic [EW-1:0]      rd_data;

   logic [AW:0]          lw;
   logic [AW+1:0]        rw;
   logic [AW-1:0]        par;
   logic [COUNT_BITS-1:0] cnt;
   logic [EW-1:0]        bestv;

   lphm_heap_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign lw  = {idx_ff, 1'b1};
   assign rw  = {1'b0, lw} + (AW+2)'(1);
   assign par = AW'((idx_ff - AW'(1)) >> 1);
   assign cnt = COUNT_BITS'(req_data.count_value);
   assign bestv = lbet_ff ? lch_ff : cur_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      next_id_in   = next_id_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      lch_in       = lch_ff;
      lbet_in      = lbet_ff;
      ent_a_in     = ent_a_ff;
      ent_b_in     = ent_b_ff;
      ph_in        = ph_ff;
      is_load_in   = is_load_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = cur_ff;
      rd_addr      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pend_in    = '0;
               is_load_in = 1'b0;
               state_in   = S_DONE;
               case (req_data.action)
                  ACT_LOAD: begin
                     is_load_in = 1'b1;
                     if (next_id_ff != ID_MAX) begin
                        next_id_in = next_id_ff + ID_BITS'(1);
                     end
                     if (cnt != '0) begin
                        if (size_ff >= CAP) begin
                           pend_in.status = STAT_FULL;
                        end else begin
                           cur_in   = {cnt, next_id_ff};
                           idx_in   = AW'(size_ff);
                           size_in  = size_ff + (AW+1)'(1);
                           state_in = S_UP_CHK;
                        end
                     end
                  end
                  ACT_PAIR: begin
                     if (size_ff < (AW+1)'(2)) begin
                        pend_in.status = STAT_FEW;
                     end else begin
                        ph_in    = 2'd0;
                        state_in = S_POP_ROOT;
                     end
                  end
                  ACT_CLEAR: begin
                     size_in    = '0;
                     next_id_in = ID_BITS'(1);
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP_ROOT: begin
            if (ph_ff == 2'd0) begin
               ent_a_in         = rd_data;
               pend_in.first_id = rd_data[ID_BITS-1:0];
            end else begin
               ent_b_in          = rd_data;
               pend_in.second_id = rd_data[ID_BITS-1:0];
            end
            size_in  = size_ff - (AW+1)'(1);
            rd_addr  = AW'(size_ff - (AW+1)'(1));
            state_in = S_POP_LAST;
         end
         S_POP_LAST: begin
            cur_in   = rd_data;
            idx_in   = '0;
            state_in = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (lw >= size_ff) begin
               wr_en    = 1'b1;
               state_in = S_NEXT;
            end else begin
               rd_addr  = lw[AW-1:0];
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            lch_in  = rd_data;
            lbet_in = rd_data > cur_ff;
            if (rw < {1'b0, size_ff}) begin
               rd_addr  = rw[AW-1:0];
               state_in = S_DN_R;
            end else if (rd_data > cur_ff) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = lw[AW-1:0];
               state_in = S_DN_CHK;
            end else begin
               wr_en    = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_DN_R: begin
            if (rd_data > bestv) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = rw[AW-1:0];
               state_in = S_DN_CHK;
            end else if (lbet_ff) begin
               wr_en    = 1'b1;
               wr_data  = lch_ff;
               idx_in   = lw[AW-1:0];
               state_in = S_DN_CHK;
            end else begin
               wr_en    = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_UP_CHK: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_NEXT;
            end else begin
               rd_addr  = par;
               state_in = S_UP_P;
            end
         end
         S_UP_P: begin
            wr_en = 1'b1;
            if (cur_ff > rd_data) begin
               wr_data  = rd_data;
               idx_in   = par;
               state_in = S_UP_CHK;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            state_in = S_DONE;
            if (!is_load_ff) begin
               case (ph_ff)
                  2'd0: begin
                     ph_in    = 2'd1;
                     state_in = S_POP_ROOT;
                  end
                  2'd1: begin
                     if (ent_a_ff > {COUNT_BITS'(1), {ID_BITS{1'b1}}}) begin
                        cur_in   = ent_a_ff - ONE_CNT;
                        ph_in    = 2'd2;
                        idx_in   = AW'(size_ff);
                        size_in  = size_ff + (AW+1)'(1);
                        state_in = S_UP_CHK;
                     end else if (ent_b_ff > {COUNT_BITS'(1), {ID_BITS{1'b1}}}) begin
                        cur_in   = ent_b_ff - ONE_CNT;
                        ph_in    = 2'd3;
                        idx_in   = AW'(size_ff);
                        size_in  = size_ff + (AW+1)'(1);
                        state_in = S_UP_CHK;
                     end
                  end
                  2'd2: begin
                     if (ent_b_ff > {COUNT_BITS'(1), {ID_BITS{1'b1}}}) begin
                        cur_in   = ent_b_ff - ONE_CNT;
                        ph_in    = 2'd3;
                        idx_in   = AW'(size_ff);
                        size_in  = size_ff + (AW+1)'(1);
                        state_in = S_UP_CHK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= '0;
         next_id_ff   <= ID_BITS'(1);
         rsp_valid_ff <= 1'b0;
         ph_ff        <= 2'd0;
         is_load_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
         ph_ff        <= ph_in;
         is_load_ff   <= is_load_in;
      end
      idx_ff   <= idx_in;
      cur_ff   <= cur_in;
      lch_ff   <= lch_in;
      lbet_ff  <= lbet_in;
      ent_a_ff <= ent_a_in;
      ent_b_ff <= ent_b_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= CAP)
      else $error("heap size above capacity");

   a_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_id_ff != '0)
      else $error("next id reached zero");

   a_up_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_CHK) |-> ({1'b0, idx_ff} < size_ff))
      else $error("sift-up index outside heap");

   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !(rsp_valid_ff && rsp_stall)) |=> rsp_valid_ff)
      else $error("finished request produced no response");

endmodule
